@@ src/isc_pkg.sv @@
// Package for the integer stack calculator: field widths, opcodes, status codes,
// ALU op codes, and the request, result and ALU control structs. No dependencies.
package isc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned INDEX_W       = 10;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_RD_TOP = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_BOT = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd4;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd5;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd6;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ONE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd5;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] operand;
    logic [INDEX_W-1:0]       index;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } out_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

endpackage

@@ src/integer_stack_calculator.sv @@
// Integer stack calculator top level: command sequencer, fill counter and output register.
// Push and errors found at acceptance go straight to S_FIN; pop and reads pass through
// S_RD1 and S_RD2. Add, subtract, multiply and divide add S_RD3 and S_ALU, using the
// one-bit-per-cycle arithmetic unit (32 steps, sign fix and result register) and two
// reads of the single read port; a zero divisor is caught after the first read.
// One request is in progress at a time; the next is taken once the result is registered.
// Synchronous active-low reset empties the stack; entry contents are kept.
module integer_stack_calculator #(
  parameter int unsigned DEPTH = isc_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  isc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output isc_pkg::out_t out_data
);
  import isc_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > INDEX_W) ? FW : INDEX_W;
  localparam int unsigned XW = (FW > COUNT_W) ? FW : COUNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_RD3  = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  logic [DATA_W-1:0]   res_value_r, res_value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  alu_ctl_t            alu_ctl;
  logic                alu_done;
  logic [DATA_W-1:0]   alu_result;

  logic [FW-1:0]       fill_m1;
  logic [CW-1:0]       idx_x;
  logic [CW-1:0]       fill_c;
  logic [CW-1:0]       top_off;
  logic [XW-1:0]       fill_x;
  logic                range_bad;

  isc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  isc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a      (mem_rdata),
    .b      (top_r),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    fill_m1   = fill_r - FW'(1);
    idx_x     = CW'(in_data.index);
    fill_c    = CW'(fill_r);
    top_off   = fill_c - CW'(1) - idx_x;
    fill_x    = XW'(fill_r);
    range_bad = (idx_x >= fill_c);
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    top_nxt        = top_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_r[AW-1:0];
    mem_wdata      = in_data.operand;
    mem_re         = 1'b0;
    mem_raddr      = addr_r;
    alu_ctl        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.opcode;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
          case (in_data.opcode)
            OP_PUSH: begin
              if (fill_r == FW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + FW'(1);
              end
            end
            OP_POP: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = fill_m1[AW-1:0];
                fill_nxt  = fill_m1;
                state_nxt = S_RD1;
              end
            end
            OP_RD_TOP: begin
              if (range_bad) begin
                res_status_nxt = ST_RANGE;
              end else begin
                addr_nxt  = top_off[AW-1:0];
                state_nxt = S_RD1;
              end
            end
            OP_RD_BOT: begin
              if (range_bad) begin
                res_status_nxt = ST_RANGE;
              end else begin
                addr_nxt  = idx_x[AW-1:0];
                state_nxt = S_RD1;
              end
            end
            default: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (fill_r == FW'(1)) begin
                res_status_nxt = ST_ONE;
              end else begin
                addr_nxt  = fill_m1[AW-1:0];
                state_nxt = S_RD1;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        mem_re    = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        top_nxt = mem_rdata;
        if (op_r inside {OP_POP, OP_RD_TOP, OP_RD_BOT}) begin
          res_value_nxt = mem_rdata;
          state_nxt     = S_FIN;
        end else if (op_r == OP_DIV && mem_rdata == '0) begin
          res_status_nxt = ST_DIVZ;
          state_nxt      = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = addr_r - AW'(1);
          state_nxt = S_RD3;
        end
      end
      S_RD3: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = op_r[1:0];
        state_nxt     = S_ALU;
      end
      S_ALU: begin
        if (alu_done) begin
          mem_we        = 1'b1;
          mem_waddr     = addr_r - AW'(1);
          mem_wdata     = alu_result;
          res_value_nxt = alu_result;
          fill_nxt      = fill_m1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = res_value_r;
          out_data_nxt.status = res_status_r;
          out_data_nxt.count  = fill_x[COUNT_W-1:0];
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    top_r        <= top_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/isc_mem.sv @@
// Stack entry storage: one write port and one read port with registered read data.
// Depends on isc_pkg for the data width and the default depth.
module isc_mem #(
  parameter int unsigned DEPTH = isc_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [isc_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [isc_pkg::DATA_W-1:0] rdata
);
  import isc_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/isc_alu.sv @@
// Iterative arithmetic unit: bit-serial add and subtract, shift-add multiply and
// restoring floor divide, one bit per cycle. Depends on isc_pkg.
module isc_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isc_pkg::alu_ctl_t          ctl,
  input  logic [isc_pkg::DATA_W-1:0] a,
  input  logic [isc_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [isc_pkg::DATA_W-1:0] result
);
  import isc_pkg::*;

  localparam int unsigned SW = $clog2(DATA_W);
  localparam logic [SW-1:0] LAST = SW'(DATA_W - 1);

  logic              busy_r, busy_nxt;
  logic              fix_r, fix_nxt;
  logic              done_r, done_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              carry_r, carry_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] result_r, result_nxt;

  logic              bit_b;
  logic              sum_bit;
  logic              carry_out;
  logic [DATA_W-1:0] mul_sum;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] abs_a;
  logic [DATA_W-1:0] abs_b;
  logic [DATA_W-1:0] quot;

  always_comb begin
    bit_b     = (op_r == ALU_SUB) ? ~y_r[0] : y_r[0];
    sum_bit   = x_r[0] ^ bit_b ^ carry_r;
    carry_out = (x_r[0] & bit_b) | (x_r[0] & carry_r) | (bit_b & carry_r);
    mul_sum   = acc_r + (y_r[0] ? x_r : '0);
    diff      = {acc_r, x_r[DATA_W-1]} - {1'b0, y_r};
    abs_a     = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
    abs_b     = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
    if (!neg_r) begin
      quot = x_r;
    end else if (acc_r != '0) begin
      quot = ~x_r;
    end else begin
      quot = ~x_r + DATA_W'(1);
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    fix_nxt    = fix_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    carry_nxt  = carry_r;
    neg_nxt    = neg_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    result_nxt = result_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      op_nxt    = ctl.op;
      carry_nxt = (ctl.op == ALU_SUB);
      neg_nxt   = a[DATA_W-1] ^ b[DATA_W-1];
      acc_nxt   = '0;
      if (ctl.op == ALU_DIV) begin
        x_nxt = abs_a;
        y_nxt = abs_b;
      end else begin
        x_nxt = a;
        y_nxt = b;
      end
    end else if (busy_r) begin
      case (op_r)
        ALU_ADD, ALU_SUB: begin
          acc_nxt   = {sum_bit, acc_r[DATA_W-1:1]};
          carry_nxt = carry_out;
          x_nxt     = {1'b0, x_r[DATA_W-1:1]};
          y_nxt     = {1'b0, y_r[DATA_W-1:1]};
        end
        ALU_MUL: begin
          acc_nxt = mul_sum;
          x_nxt   = {x_r[DATA_W-2:0], 1'b0};
          y_nxt   = {1'b0, y_r[DATA_W-1:1]};
        end
        default: begin
          if (!diff[DATA_W]) begin
            acc_nxt = diff[DATA_W-1:0];
          end else begin
            acc_nxt = {acc_r[DATA_W-2:0], x_r[DATA_W-1]};
          end
          x_nxt = {x_r[DATA_W-2:0], ~diff[DATA_W]};
        end
      endcase
      cnt_nxt = cnt_r + SW'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      fix_nxt    = 1'b0;
      done_nxt   = 1'b1;
      result_nxt = (op_r == ALU_DIV) ? quot : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    op_r     <= op_nxt;
    carry_r  <= carry_nxt;
    neg_r    <= neg_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule
